### rtl/text_console_cursor_engine_macros.svh
// ----------------------------------------------------------------------------
// Text console cursor engine assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Geometry constants, character codes, command and result types.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;
	localparam int TAB_SPACES   = 4;
	localparam int TAB_W        = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd126;

	localparam logic [8:0] COLS_MAX   = 9'd256;
	localparam logic [7:0] ROWS_MAX   = 8'd128;
	localparam logic [8:0] COLS_RESET = 9'd80;
	localparam logic [7:0] ROWS_RESET = 8'd25;

	typedef enum logic [2:0] {
		REG_DISPLAY_ENABLE   = 3'd0,
		REG_TEXT_COLUMNS     = 3'd1,
		REG_TEXT_ROWS        = 3'd2,
		REG_FOREGROUND_COLOR = 3'd3,
		REG_BACKGROUND_COLOR = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_SERIAL = 2'd0,
		OP_DRAW   = 2'd1,
		OP_SCROLL = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		CLS_PLAIN  = 3'd0,
		CLS_LF_SER = 3'd1,
		CLS_LF     = 3'd2,
		CLS_CR     = 3'd3,
		CLS_TAB    = 3'd4,
		CLS_BS     = 3'd5,
		CLS_PRINT  = 3'd6
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] code;
	} cmd_t;

	typedef struct packed {
		logic [8:0] cols;
		logic [7:0] rows;
	} cfg_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  code;
		logic [10:0] px;
		logic [10:0] py;
		logic        last;
	} res_t;

	function automatic logic [8:0] eff_cols_f(input logic [8:0] c);
		if (c == 9'd0)
			return 9'd1;
		else if (c > COLS_MAX)
			return COLS_MAX;
		else
			return c;
	endfunction

	function automatic logic [7:0] eff_rows_f(input logic [7:0] r);
		if (r == 8'd0)
			return 8'd1;
		else if (r > ROWS_MAX)
			return ROWS_MAX;
		else
			return r;
	endfunction

endpackage

### rtl/tcce_queue.sv
// ----------------------------------------------------------------------------
// Text console cursor engine command queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module tcce_queue
	import tcce_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_data,
	input  logic  pop,
	output cmd_t  head,
	output logic  full,
	output logic  nempty
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nempty = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// Text console cursor engine front end
// Accepts character bytes, classifies them and feeds the command queue.
// ----------------------------------------------------------------------------
module tcce_front
	import tcce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       display_enable,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_data
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	function automatic cls_t classify(input logic [7:0] c, input logic en);
		cls_t k;
		k = CLS_PLAIN;
		if (c == CH_LF)
			k = en ? CLS_LF : CLS_LF_SER;
		else if (!en)
			k = CLS_PLAIN;
		else if (c == CH_CR)
			k = CLS_CR;
		else if (c == CH_TAB)
			k = CLS_TAB;
		else if (c == CH_BS)
			k = CLS_BS;
		else if (c >= PRINT_LO && c <= PRINT_HI)
			k = CLS_PRINT;
		return k;
	endfunction

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.cls  <= classify(char_code, display_enable);
			cmd_s1.code <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (push)
			valid_s1 <= 1'b0;
	end

endmodule

### rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// Text console cursor engine back end
// Sequences serial, draw and scroll results and keeps the cursor.
// ----------------------------------------------------------------------------
module tcce_back
	import tcce_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_nempty,
	input  cmd_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t res
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SER    = 8'b0000_0010,
		S_LF2    = 8'b0000_0100,
		S_SCROLL = 8'b0000_1000,
		S_TSER   = 8'b0001_0000,
		S_DRAW   = 8'b0010_0000,
		S_BS1    = 8'b0100_0000,
		S_BS2    = 8'b1000_0000
	} state_t;

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [7:0]       col_q, col_d, old_col_q;
	logic [6:0]       row_q, row_d, old_row_q;
	logic [TAB_W-1:0] tcnt_q, tcnt_d;
	logic             ov_q;
	res_t             res_q, res_d;

	logic [8:0] eff_cols;
	logic [7:0] eff_rows;
	logic [8:0] col_inc;
	logic [7:0] row_inc;
	logic       wrap, nl_scroll, tab_more, is_lf;
	logic       go, step, done, load;
	logic [7:0] pc;
	logic [6:0] pr;

	assign eff_cols  = eff_cols_f(cfg.cols);
	assign eff_rows  = eff_rows_f(cfg.rows);
	assign col_inc   = {1'b0, col_q} + 9'd1;
	assign row_inc   = {1'b0, row_q} + 8'd1;
	assign wrap      = (col_inc >= eff_cols);
	assign nl_scroll = (row_inc >= eff_rows);
	assign tab_more  = (cmd_q.cls == CLS_TAB) && (tcnt_q != TAB_W'(TAB_SPACES - 1));
	assign is_lf     = (cmd_q.cls == CLS_LF) || (cmd_q.cls == CLS_LF_SER);

	assign go    = !ov_q || !out_stall;
	assign step  = (state_q != S_IDLE) && go;
	assign load  = q_nempty && ((state_q == S_IDLE) || (step && done));
	assign q_pop = load;

	assign out_valid = ov_q;
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		col_d   = col_q;
		row_d   = row_q;
		tcnt_d  = tcnt_q;
		done    = 1'b0;
		pc      = col_q;
		pr      = row_q;
		res_d   = '0;
		res_d.kind = OP_SERIAL;
		case (state_q)
			S_SER: begin
				res_d.code = is_lf ? CH_CR : cmd_q.code;
				case (cmd_q.cls)
					CLS_LF, CLS_LF_SER: state_d = S_LF2;
					CLS_TAB: begin
						tcnt_d  = '0;
						state_d = S_TSER;
					end
					CLS_BS:    state_d = S_BS1;
					CLS_PRINT: state_d = S_DRAW;
					CLS_CR: begin
						col_d = '0;
						done  = 1'b1;
					end
					default: done = 1'b1;
				endcase
			end
			S_LF2: begin
				res_d.code = CH_LF;
				if (cmd_q.cls == CLS_LF_SER) begin
					done = 1'b1;
				end else begin
					col_d = '0;
					if (nl_scroll) begin
						state_d = S_SCROLL;
					end else begin
						row_d = row_inc[6:0];
						done  = 1'b1;
					end
				end
			end
			S_SCROLL: begin
				res_d.kind = OP_SCROLL;
				if (tab_more) begin
					tcnt_d  = tcnt_q + 1'b1;
					state_d = S_TSER;
				end else begin
					done = 1'b1;
				end
			end
			S_TSER: begin
				res_d.code = CH_SPACE;
				state_d    = S_DRAW;
			end
			S_DRAW: begin
				res_d.kind = OP_DRAW;
				res_d.code = (cmd_q.cls == CLS_TAB) ? CH_SPACE : cmd_q.code;
				if (wrap) begin
					col_d = '0;
					if (nl_scroll)
						state_d = S_SCROLL;
					else
						row_d = row_inc[6:0];
				end else begin
					col_d = col_inc[7:0];
				end
				if (!(wrap && nl_scroll)) begin
					if (tab_more) begin
						tcnt_d  = tcnt_q + 1'b1;
						state_d = S_TSER;
					end else begin
						done = 1'b1;
					end
				end
			end
			S_BS1: begin
				res_d.kind = OP_DRAW;
				res_d.code = CH_SPACE;
				if (col_q != 8'd0) begin
					col_d = col_q - 8'd1;
				end else if (row_q != 7'd0) begin
					row_d = row_q - 7'd1;
					col_d = 8'(eff_cols - 9'd1);
				end
				pc = col_d;
				pr = row_d;
				if ((col_q != 8'd0) || (row_q != 7'd0))
					state_d = S_BS2;
				else
					done = 1'b1;
			end
			S_BS2: begin
				res_d.kind = OP_DRAW;
				res_d.code = CH_SPACE;
				pc   = old_col_q;
				pr   = old_row_q;
				done = 1'b1;
			end
			default: done = 1'b0;
		endcase
		if (res_d.kind == OP_DRAW) begin
			res_d.px = 11'(32'(pc) * GLYPH_WIDTH);
			res_d.py = 11'(32'(pr) * GLYPH_HEIGHT);
		end
		res_d.last = done;
	end

	always_ff @(posedge clk) begin
		if (load)
			cmd_q <= q_head;
		if (step) begin
			res_q <= res_d;
			if (state_q == S_BS1) begin
				old_col_q <= col_q;
				old_row_q <= row_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			tcnt_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (go)
				ov_q <= step;
			if (step) begin
				col_q  <= col_d;
				row_q  <= row_d;
				tcnt_q <= tcnt_d;
			end
			if (load)
				state_q <= S_SER;
			else if (step)
				state_q <= done ? S_IDLE : state_d;
		end
	end

endmodule

### rtl/text_console_cursor_engine.sv
// Path: an accepted input is registered in the front stage, written to the queue and
// loaded into the back end, whose results leave the output register one per cycle
// unless out_stall holds it; a character causes 1 to 13, the next follows at once.
// Reset: registers take their defaults, the cursor returns to column 0, row 0,
// and the front stage, queue and output register come up empty.
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character byte in; serial, glyph draw and scroll operations out.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
	import tcce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  op_kind,
	output logic [7:0]  glyph_code,
	output logic [10:0] pixel_x,
	output logic [10:0] pixel_y,
	output logic        last_of_run
);

	logic       display_enable_q;
	logic [8:0] text_columns_q;
	logic [7:0] text_rows_q;
	cfg_t       cfg;
	logic       q_push, q_pop, q_full, q_nempty;
	cmd_t       q_in, q_head;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_enable_q <= 1'b0;
			text_columns_q   <= COLS_RESET;
			text_rows_q      <= ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DISPLAY_ENABLE: display_enable_q <= cfg_data[0];
				REG_TEXT_COLUMNS:   text_columns_q   <= cfg_data[8:0];
				REG_TEXT_ROWS:      text_rows_q      <= cfg_data[7:0];
				default:            display_enable_q <= display_enable_q;
			endcase
		end
	end

	assign cfg.cols = text_columns_q;
	assign cfg.rows = text_rows_q;

	tcce_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.display_enable (display_enable_q),
		.q_full         (q_full),
		.push           (q_push),
		.push_data      (q_in)
	);

	tcce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.nempty    (q_nempty)
	);

	tcce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_nempty  (q_nempty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign op_kind     = res.kind;
	assign glyph_code  = res.code;
	assign pixel_x     = res.px;
	assign pixel_y     = res.py;
	assign last_of_run = res.last;

endmodule

### rtl/tcce_checker.sv
// ----------------------------------------------------------------------------
// Text console cursor engine checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_macros.svh"

module tcce_checker
	import tcce_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  op_kind,
	input logic [7:0]  glyph_code,
	input logic [10:0] pixel_x,
	input logic [10:0] pixel_y,
	input logic        last_of_run
);

	`TCCE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(op_kind) && $stable(glyph_code) && $stable(pixel_x) && $stable(pixel_y) && $stable(last_of_run), "stalled result changed")
	`TCCE_ASSERT_IMP(a_scroll_zero, out_valid && op_kind == OP_SCROLL, glyph_code == 8'd0 && pixel_x == 11'd0 && pixel_y == 11'd0, "scroll with nonzero fields")
	`TCCE_ASSERT_IMP(a_serial_pos, out_valid && op_kind == OP_SERIAL, pixel_x == 11'd0 && pixel_y == 11'd0, "serial transfer with a pixel position")
	`TCCE_ASSERT_IMP(a_draw_code, out_valid && op_kind == OP_DRAW, glyph_code >= PRINT_LO && glyph_code <= PRINT_HI, "draw of a nonprintable code")

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);
